// File: src/fltr_pkg.sv
// ----------------------------------------------------------------------------
// fltr_pkg
// shared types, register indexes and trim codes for the fill level rate trim
// ----------------------------------------------------------------------------
package fltr_pkg;

  // width of the internal fill level
  localparam int LEVEL_BITS = 16;
  // width used for threshold compares (covers both level and threshold)
  localparam int CMP_BITS   = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;

  localparam int FILL_BITS  = 16;
  localparam int IDX_BITS   = 8;
  localparam int DATA_BITS  = 16;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [7:0]            count_t;
  typedef logic signed [1:0]     speed_t;
  typedef logic [IDX_BITS-1:0]   cfg_idx_t;
  typedef logic [DATA_BITS-1:0]  cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_LOW_THRESHOLD  = 8'd0;
  localparam cfg_idx_t REG_HIGH_THRESHOLD = 8'd1;
  localparam cfg_idx_t REG_WINDOW_LEN     = 8'd2;
  localparam cfg_idx_t REG_SETTLE_COUNT   = 8'd3;

  // register reset values
  localparam logic [15:0] LOW_THRESHOLD_RST  = 16'd96;
  localparam logic [15:0] HIGH_THRESHOLD_RST = 16'd240;
  localparam count_t      WINDOW_LEN_RST     = 8'd8;
  localparam count_t      SETTLE_COUNT_RST   = 8'd4;

  // trim codes
  localparam speed_t SPEED_SLOWER  = 2'sb11;
  localparam speed_t SPEED_NOMINAL = 2'sb00;
  localparam speed_t SPEED_FASTER  = 2'sb01;

  localparam count_t COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] low_threshold;
    logic [15:0] high_threshold;
    count_t      window_len;
    count_t      settle_count;
  } cfg_t;

  // outcome of one item passed from the tracker to the result stage
  typedef struct packed {
    logic   emit;
    speed_t speed;
  } decision_t;

endpackage

// File: src/fltr_item_if.sv
// ----------------------------------------------------------------------------
// fltr_item_if
// input channel: one fill reading with its active flag per word
// ----------------------------------------------------------------------------
interface fltr_item_if;
  logic        valid;
  logic        ready;
  logic        active;
  logic [15:0] fill_bytes;

  modport source (output valid, output active, output fill_bytes, input ready);
  modport sink   (input valid, input active, input fill_bytes, output ready);
endinterface

// File: src/fltr_result_if.sv
// ----------------------------------------------------------------------------
// fltr_result_if
// output channel: one new speed trim per word
// ----------------------------------------------------------------------------
interface fltr_result_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] speed_adjust;

  modport source (output valid, output speed_adjust, input ready);
  modport sink   (input valid, input speed_adjust, output ready);
endinterface

// File: src/fltr_cfg_if.sv
// ----------------------------------------------------------------------------
// fltr_cfg_if
// configuration write channel: register index and write data per word
// ----------------------------------------------------------------------------
interface fltr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/fifo_level_rate_trim_core.sv
// ----------------------------------------------------------------------------
// fifo_level_rate_trim_core
// buffer fill level to resampler speed trim
//
// channel  | dir | payload                          | handshake
// ---------+-----+----------------------------------+------------
// item     | in  | active, fill_bytes[15:0]         | valid/ready
// result   | out | speed_adjust[1:0] signed         | valid/ready
// cfg      | in  | index[7:0], data[15:0]           | valid/ready
//
// an accepted word is held in the input register; when the result stage is
// free, it updates the tracker state and loads the result register, which
// offers the trim on the result channel when a new one is due; one word
// per cycle sustained while the result register is free
// the only limit is the single result register: while it holds an untaken
// trim, a word in the input register waits there and item.ready drops
// reset is synchronous, active high, and restores the configuration and
// tracker defaults and clears both valid flags
// ----------------------------------------------------------------------------
module fifo_level_rate_trim_core (
  input  logic          clk,
  input  logic          rst,
  fltr_item_if.sink     item,
  fltr_result_if.source result,
  fltr_cfg_if.sink      cfg
);
  import fltr_pkg::*;

  cfg_t      regs;
  decision_t decision;

  // input register
  logic        in_valid;
  logic        in_active;
  logic [15:0] in_fill;

  logic out_free;
  logic advance;

  // word leaves the input register when the result stage can take it
  assign advance    = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_active <= item.active;
      in_fill   <= item.fill_bytes;
    end
  end

  // configuration registers
  fltr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // minimum tracking and decision
  fltr_track u_track (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .step       (advance),
    .active     (in_active),
    .fill_bytes (in_fill),
    .decision   (decision)
  );

  // result register, only loaded with a word when a settled decision gives a new trim
  fltr_out_stage u_out_stage (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .decision       (decision),
    .busy_next_free (out_free),
    .result         (result)
  );

endmodule

// File: src/fltr_cfg_regs.sv
// ----------------------------------------------------------------------------
// fltr_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
module fltr_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  fltr_cfg_if.sink     cfg,
  output fltr_pkg::cfg_t regs
);
  import fltr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_threshold  <= LOW_THRESHOLD_RST;
      regs.high_threshold <= HIGH_THRESHOLD_RST;
      regs.window_len     <= WINDOW_LEN_RST;
      regs.settle_count   <= SETTLE_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LOW_THRESHOLD:  regs.low_threshold  <= cfg.data;
        REG_HIGH_THRESHOLD: regs.high_threshold <= cfg.data;
        REG_WINDOW_LEN:     regs.window_len     <= cfg.data[7:0];
        REG_SETTLE_COUNT:   regs.settle_count   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/fltr_track.sv
// ----------------------------------------------------------------------------
// fltr_track
// windowed minimum tracking and trim decision, one item per step
// ----------------------------------------------------------------------------
module fltr_track (
  input  logic                clk,
  input  logic                rst,
  input  fltr_pkg::cfg_t      regs,
  input  logic                step,
  input  logic                active,
  input  logic [15:0]         fill_bytes,
  output fltr_pkg::decision_t decision
);
  import fltr_pkg::*;

  level_t run_min;
  level_t prev_min;
  count_t item_count;
  speed_t last_speed;
  logic   speed_known;

  level_t level;
  count_t cnt_inc;
  count_t cnt;
  logic   restart;
  level_t run_min_next;
  level_t prev_min_next;
  level_t lowest;
  logic [CMP_BITS-1:0] lowest_ext;
  logic [CMP_BITS-1:0] low_ext;
  logic [CMP_BITS-1:0] high_ext;
  speed_t trim;
  logic   decide;

  always_comb begin
    level   = LEVEL_BITS'({1'b0, fill_bytes[FILL_BITS-1:1]});
    cnt_inc = (item_count == COUNT_MAX) ? COUNT_MAX : item_count + 8'd1;
    restart = (level < run_min) || (cnt_inc >= regs.window_len);
    cnt     = restart ? '0 : cnt_inc;

    // a restart also copies the new minimum into the previous-window slot
    run_min_next  = restart ? level : run_min;
    prev_min_next = restart ? level : prev_min;
    decide        = (cnt >= regs.settle_count);

    lowest     = (run_min_next < prev_min_next) ? run_min_next : prev_min_next;
    lowest_ext = CMP_BITS'(lowest);
    low_ext    = CMP_BITS'(regs.low_threshold);
    high_ext   = CMP_BITS'(regs.high_threshold);

    if (lowest_ext <= low_ext) begin
      trim = SPEED_SLOWER;
    end else if (lowest_ext > high_ext) begin
      trim = SPEED_FASTER;
    end else begin
      trim = SPEED_NOMINAL;
    end

    decision.speed = trim;
    decision.emit  = active && decide && !(speed_known && (trim == last_speed));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min     <= '1;
      prev_min    <= '0;
      item_count  <= '0;
      last_speed  <= SPEED_NOMINAL;
      speed_known <= 1'b0;
    end else if (step) begin
      if (!active) begin
        speed_known <= 1'b0;
        run_min     <= '1;
      end else begin
        run_min    <= run_min_next;
        prev_min   <= prev_min_next;
        item_count <= cnt;
        if (decision.emit) begin
          speed_known <= 1'b1;
          last_speed  <= trim;
        end
      end
    end
  end

endmodule

// File: src/fltr_cfg_regs_dummy_guard.sv
// ----------------------------------------------------------------------------
// fltr_out_stage
// result register: holds one trim word until the consumer takes it
// ----------------------------------------------------------------------------
module fltr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fltr_pkg::decision_t decision,
  output logic                busy_next_free,
  fltr_result_if.source       result
);
  import fltr_pkg::*;

  logic   valid;
  speed_t speed;

  // free to take a new word this cycle
  assign busy_next_free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= decision.emit;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && decision.emit) begin
      speed <= decision.speed;
    end
  end

  assign result.valid        = valid;
  assign result.speed_adjust = speed;

endmodule

// File: dv/tb_fifo_level_rate_trim_core.sv
// ----------------------------------------------------------------------------
// tb_fifo_level_rate_trim_core
// self-checking bench for the fill level rate trim core: fill readings are
// streamed through the item channel under random idling and a long result
// hold-off, a behavioural tracker in the bench predicts every speed trim word,
// and each word taken from the result channel is compared in order
// ----------------------------------------------------------------------------
module tb_fifo_level_rate_trim_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fltr_pkg::*;

  localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 300;    // long result back-pressure stretch
  localparam int DRAIN_CYCLES = 8;      // input and result register drain plus margin
  localparam int LEVEL_TOP    = 32767;  // largest level a 16-bit fill can give
  localparam int PHASES       = 10;

  // index outside the register map, must be ignored
  localparam cfg_idx_t REG_UNUSED = 8'hA5;

  typedef struct packed {
    logic        active;
    logic [15:0] fill;
  } reading_t;

  logic clk = 1'b0;
  logic rst;

  fltr_item_if   item_if ();
  fltr_result_if result_if ();
  fltr_cfg_if    cfg_if ();

  fifo_level_rate_trim_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always #4 clk = ~clk;

  // stimulus and expectations
  reading_t fills_pending[$];
  speed_t   speeds_due[$];

  // mirror of the configuration registers
  logic [15:0] lim_low;
  logic [15:0] lim_high;
  count_t      win_len;
  count_t      settle_len;

  // mirror of the tracker state
  level_t trk_run_min;
  level_t trk_prev_min;
  count_t trk_count;
  speed_t trk_last;
  logic   trk_known;

  int  send_idle;
  int  recv_idle;
  bit  holding;
  bit  holdoff_req;
  bit  item_taken;
  int  quiet_cycles;
  int  fail_count;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // one fill reading through the tracker; queues a trim word when one is due
  function automatic void track_fill(input logic act, input logic [15:0] fill);
    level_t lvl;
    level_t lowest;
    count_t cnt;
    speed_t trim;
    if (!act) begin
      // stream stopped: forget the last speed and restart the minimum search
      trk_known   = 1'b0;
      trk_run_min = '1;
      return;
    end
    lvl = level_t'(fill >> 1);
    cnt = (trk_count != COUNT_MAX) ? count_t'(trk_count + 1) : COUNT_MAX;
    if (lvl < trk_run_min || cnt >= win_len) begin
      trk_run_min = lvl;
      cnt         = '0;
    end
    if (cnt == 0) trk_prev_min = trk_run_min;
    trk_count = cnt;
    if (cnt < settle_len) return;
    lowest = (trk_run_min < trk_prev_min) ? trk_run_min : trk_prev_min;
    if (lowest <= lim_low) trim = SPEED_SLOWER;
    else if (lowest > lim_high) trim = SPEED_FASTER;
    else trim = SPEED_NOMINAL;
    if (trk_known && trim == trk_last) return;
    trk_known = 1'b1;
    trk_last  = trim;
    speeds_due.push_back(trim);
  endfunction

  // random level in [a, b], both ends clipped to what a fill reading can give
  function automatic int rand_between(input int a, input int b);
    int lo_b;
    int hi_b;
    lo_b = (a < 0) ? 0 : (a > LEVEL_TOP) ? LEVEL_TOP : a;
    hi_b = (b < 0) ? 0 : (b > LEVEL_TOP) ? LEVEL_TOP : b;
    if (lo_b > hi_b) return $urandom_range(lo_b, hi_b);
    return $urandom_range(hi_b, lo_b);
  endfunction

  // level in a trim band of the current settings, often right at its edge
  function automatic int pick_level(input int band);
    int lo;
    int hi;
    bit near;
    lo   = int'(lim_low);
    hi   = int'(lim_high);
    near = 1'($urandom_range(1));
    case (band)
      0: return near ? rand_between(lo - 3, lo) : rand_between(0, lo);
      1: begin
        if (lo >= hi) return rand_between(0, LEVEL_TOP);
        if (near) return $urandom_range(1) ? rand_between(lo + 1, lo + 3)
                                            : rand_between(hi - 2, hi);
        return rand_between(lo + 1, hi);
      end
      default: return near ? rand_between(hi + 1, hi + 3)
                           : rand_between(hi + 1, LEVEL_TOP);
    endcase
  endfunction

  // random readings: bursts that sit in one trim band, with noise and stops
  task automatic queue_readings(input int n);
    int       band;
    int       burst;
    int       lvl;
    int       pick;
    reading_t rd;
    band  = 0;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        band  = $urandom_range(2);
        burst = $urandom_range(12, 1);
      end
      burst--;
      pick = $urandom_range(99);
      if (pick < 4) begin
        rd = '{active: 1'b0, fill: 16'($urandom_range(16'hFFFF))};
      end else if (pick < 12) begin
        rd = '{active: 1'b1, fill: 16'($urandom_range(16'hFFFF))};
      end else begin
        lvl = pick_level(band);
        rd  = '{active: 1'b1, fill: {lvl[14:0], 1'($urandom_range(1))}};
      end
      fills_pending.push_back(rd);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // block is idle once every reading is in and every trim word is out
  task automatic wait_idle();
    do @(posedge clk);
    while (fills_pending.size() != 0 || item_if.valid || speeds_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register settings of one phase, extremes included
  task automatic set_phase(input int p, output int n);
    logic [15:0] lo;
    lo = 16'($urandom_range(2000));
    case (p)
      0: begin
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(REG_LOW_THRESHOLD, 16'd0);
        write_reg(REG_HIGH_THRESHOLD, 16'hFFFF);
        write_reg(REG_WINDOW_LEN, 16'd1);
        write_reg(REG_SETTLE_COUNT, 16'd0);
        n = 100;
      end
      1: begin
        // low above high, zero window; upper data bits are dropped
        write_reg(REG_LOW_THRESHOLD, 16'hFFFF);
        write_reg(REG_HIGH_THRESHOLD, 16'd0);
        write_reg(REG_WINDOW_LEN, 16'hFF00);
        write_reg(REG_SETTLE_COUNT, 16'h0100);
        n = 70;
      end
      2: begin
        write_reg(REG_LOW_THRESHOLD, 16'd100);
        write_reg(REG_HIGH_THRESHOLD, 16'd200);
        write_reg(REG_WINDOW_LEN, 16'd4);
        write_reg(REG_SETTLE_COUNT, 16'd1);
        n = 150;
      end
      3: begin
        write_reg(REG_LOW_THRESHOLD, 16'd300);
        write_reg(REG_HIGH_THRESHOLD, 16'd301);
        write_reg(REG_WINDOW_LEN, 16'd255);
        write_reg(REG_SETTLE_COUNT, 16'd2);
        n = 100;
      end
      4: begin
        // settle equal to window: no decision can be reached
        write_reg(REG_LOW_THRESHOLD, 16'd20000);
        write_reg(REG_HIGH_THRESHOLD, 16'd30000);
        write_reg(REG_WINDOW_LEN, 16'd3);
        write_reg(REG_SETTLE_COUNT, 16'd3);
        n = 40;
      end
      5: begin
        write_reg(REG_LOW_THRESHOLD, lo);
        write_reg(REG_HIGH_THRESHOLD, 16'(lo + $urandom_range(400, 1)));
        write_reg(REG_WINDOW_LEN, 16'hAB06);
        write_reg(REG_SETTLE_COUNT, 16'h5402);
        n = 150;
      end
      6: begin
        write_reg(REG_LOW_THRESHOLD, LOW_THRESHOLD_RST);
        write_reg(REG_HIGH_THRESHOLD, HIGH_THRESHOLD_RST);
        write_reg(REG_WINDOW_LEN, 16'(WINDOW_LEN_RST));
        write_reg(REG_SETTLE_COUNT, 16'(SETTLE_COUNT_RST));
        n = 100;
      end
      7: begin
        // equal thresholds, short window: plenty of trim words
        write_reg(REG_LOW_THRESHOLD, 16'd5000);
        write_reg(REG_HIGH_THRESHOLD, 16'd5000);
        write_reg(REG_WINDOW_LEN, 16'd2);
        write_reg(REG_SETTLE_COUNT, 16'd1);
        n = 100;
      end
      8: begin
        write_reg(REG_LOW_THRESHOLD, 16'd32767);
        write_reg(REG_HIGH_THRESHOLD, 16'd32766);
        write_reg(REG_WINDOW_LEN, 16'd10);
        write_reg(REG_SETTLE_COUNT, 16'd0);
        n = 80;
      end
      default: begin
        write_reg(REG_LOW_THRESHOLD, lo);
        write_reg(REG_HIGH_THRESHOLD, 16'h7FFF);
        write_reg(REG_WINDOW_LEN, 16'd255);
        write_reg(REG_SETTLE_COUNT, 16'd255);
        n = 30;
      end
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // item driver: a word stays on the channel until taken
  always @(negedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || item_taken) begin
      if (fills_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        reading_t rd;
        rd = fills_pending.pop_front();
        item_if.valid      <= 1'b1;
        item_if.active     <= rd.active;
        item_if.fill_bytes <= rd.fill;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure, random or held off for a long stretch
  always @(negedge clk) begin
    result_if.ready <= !holding && ($urandom_range(99) >= recv_idle);
  end

  // hold-off counted in its own process while the sender keeps going
  initial begin
    holding = 1'b0;
    wait (holdoff_req);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // monitor: feeds the tracker, checks trim words, mirrors register writes
  always @(posedge clk) begin
    if (rst) begin
      item_taken   = 1'b0;
      quiet_cycles = 0;
    end else begin
      item_taken = item_if.valid && item_if.ready;
      if (item_taken) track_fill(item_if.active, item_if.fill_bytes);

      if (result_if.valid && result_if.ready) begin
        if (speeds_due.size() == 0) begin
          report_mismatch($sformatf("unexpected speed word %0d",
                                    result_if.speed_adjust));
        end else begin
          speed_t want;
          want = speeds_due.pop_front();
          if (result_if.speed_adjust !== want)
            report_mismatch($sformatf("speed_adjust %0d, predicted %0d",
                                      result_if.speed_adjust, want));
        end
      end

      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_LOW_THRESHOLD:  lim_low    = cfg_if.data;
          REG_HIGH_THRESHOLD: lim_high   = cfg_if.data;
          REG_WINDOW_LEN:     win_len    = cfg_if.data[7:0];
          REG_SETTLE_COUNT:   settle_len = cfg_if.data[7:0];
          default: ;
        endcase
      end

      // watchdog on a channel set that has gone silent
      if (item_taken || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // directed readings under reset settings: extremes, band edges, stops
  localparam reading_t DIRECTED [24] = '{
    '{1'b0, 16'hFFFF}, '{1'b1, 16'hFFFF}, '{1'b1, 16'hFFFE}, '{1'b1, 16'hFFFF},
    '{1'b1, 16'hFFFF}, '{1'b1, 16'hFFFF}, '{1'b1, 16'hFFFF}, '{1'b1, 16'd482},
    '{1'b1, 16'd481},  '{1'b1, 16'd480},  '{1'b1, 16'd480},  '{1'b1, 16'd480},
    '{1'b1, 16'd480},  '{1'b1, 16'd480},  '{1'b1, 16'd193},  '{1'b1, 16'd194},
    '{1'b1, 16'h5555}, '{1'b1, 16'hAAAA}, '{1'b0, 16'd0},    '{1'b1, 16'd0},
    '{1'b1, 16'd1},    '{1'b1, 16'd0},    '{1'b1, 16'd0},    '{1'b1, 16'd0}
  };

  initial begin
    int n;
    // every input known from time zero
    rst                = 1'b1;
    item_if.valid      = 1'b0;
    item_if.active     = 1'b0;
    item_if.fill_bytes = '0;
    result_if.ready    = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    holdoff_req        = 1'b0;
    fail_count         = 0;

    // mirror starts at the reset defaults
    lim_low      = LOW_THRESHOLD_RST;
    lim_high     = HIGH_THRESHOLD_RST;
    win_len      = WINDOW_LEN_RST;
    settle_len   = SETTLE_COUNT_RST;
    trk_run_min  = '1;
    trk_prev_min = '0;
    trk_count    = '0;
    trk_last     = SPEED_NOMINAL;
    trk_known    = 1'b0;

    send_idle = 20;
    recv_idle = 85;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) fills_pending.push_back(DIRECTED[i]);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      // idling: slow receiver, then slow sender, then flat out
      if (p < 3) begin
        send_idle = 20;
        recv_idle = 85;
      end else if (p < 6) begin
        send_idle = 85;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_phase(p, n);
      if (p == 7) holdoff_req = 1'b1;
      queue_readings(n);
      wait_idle();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
